[rtl/xbsc_pkg.sv]
// ---------------------------------------------------------------------------
// xbsc_pkg - shared types and constants of the xor basis subset counter
// Word width, modulus, opcodes and the command/status bundles that pass
// between the controller and the datapath.
// ---------------------------------------------------------------------------
package xbsc_pkg;

    // basis word width and the field widths at the ports
    localparam int WORD_BITS = 20;
    localparam int VALUE_W   = 20;
    localparam int COUNT_W   = 30;
    localparam int BIT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int RANK_W    = $clog2(WORD_BITS + 1);

    // modulus of the subset count
    localparam logic [COUNT_W-1:0] PRIME = COUNT_W'(1000000007);

    // opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [BIT_W-1:0]     t_bit_idx;

    // controller to datapath
    typedef struct packed {
        logic load;    // take the new request
        logic step;    // one reduction step
        logic commit;  // update basis / power, latch the result
        logic emit;    // move the result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic stop;      // reduction finishes in this cycle
        logic out_free;  // output register can take a result
    } t_sts;

    // input value cut or zero-extended to the basis width
    function automatic t_word to_word(input logic [VALUE_W-1:0] value);
        t_word w;
        w = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (i < VALUE_W) begin
                w[i] = value[i];
            end
        end
        return w;
    endfunction

endpackage

[rtl/xbsc_if.sv]
// ---------------------------------------------------------------------------
// xbsc_in_if / xbsc_out_if - request and result channels
// Valid/ready handshake; a request moves when both are high at the edge.
// ---------------------------------------------------------------------------
interface xbsc_in_if;
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic [xbsc_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface xbsc_out_if;
    logic                           valid;
    logic                           ready;
    logic                           in_span;
    logic [xbsc_pkg::COUNT_W-1:0]   count;

    modport source (output valid, output in_span, output count, input ready);
    modport sink   (input valid, input in_span, input count, output ready);
endinterface

[rtl/xbsc_ctrl.sv]
// ---------------------------------------------------------------------------
// xbsc_ctrl - sequencing controller
// Accepts a request when idle, runs the reduction one slot per cycle,
// commits the outcome and hands the result to the output register.
// ---------------------------------------------------------------------------
module xbsc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  xbsc_pkg::t_sts   i_sts,
    output xbsc_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_RUN;
            end
            S_RUN: begin
                if (i_sts.stop) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.step    = (r_state == S_RUN) && !i_sts.stop;
    assign o_cmd.commit  = (r_state == S_RUN) && i_sts.stop;
    assign o_cmd.emit    = (r_state == S_EMIT) && i_sts.out_free;

`ifndef SYNTHESIS
    // a request is never taken while one is in flight
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_RUN))
        else $error("load did not start a reduction");
    // commit is always followed by the emit state
    a_commit_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == S_EMIT))
        else $error("commit not followed by emit state");
    // at most one command per cycle
    a_no_double_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.step, o_cmd.commit, o_cmd.emit}))
        else $error("more than one command at once");
`endif

endmodule

[rtl/xbsc_dp.sv]
// ---------------------------------------------------------------------------
// xbsc_dp - basis, reduction datapath and output register
// Holds the basis rows with their valid bits, the rank and the free power
// modulo the prime, and reduces the working word one slot per step.
// ---------------------------------------------------------------------------
module xbsc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  xbsc_pkg::t_cmd                    i_cmd,
    output xbsc_pkg::t_sts                    o_sts,
    input  logic                              i_opcode,
    input  logic [xbsc_pkg::VALUE_W-1:0]      i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_in_span,
    output logic [xbsc_pkg::COUNT_W-1:0]      o_count
);

    localparam int WB = xbsc_pkg::WORD_BITS;

    // basis store, valid bits cleared by reset
    xbsc_pkg::t_word                  r_rows [WB];
    logic [WB-1:0]                    r_valid;
    logic [xbsc_pkg::RANK_W-1:0]      r_rank;
    logic [xbsc_pkg::COUNT_W-1:0]     r_power;

    // working request
    logic                             r_op;
    xbsc_pkg::t_word                  r_w;
    xbsc_pkg::t_bit_idx               r_bit;

    // finished result and output register
    logic                             r_res_span;
    logic [xbsc_pkg::COUNT_W-1:0]     r_res_count;
    logic                             r_out_valid;
    logic                             r_out_span;
    logic [xbsc_pkg::COUNT_W-1:0]     r_out_count;

    logic                             hit;
    logic                             empty_slot;
    logic                             residue_zero;
    logic [xbsc_pkg::COUNT_W:0]       dbl;
    logic [xbsc_pkg::COUNT_W-1:0]     n_power;

    // current slot
    assign hit          = r_w[r_bit];
    assign empty_slot   = !r_valid[r_bit];
    assign residue_zero = !(hit && empty_slot);

    assign o_sts.stop     = (hit && empty_slot) || (r_bit == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // doubled power modulo the prime
    assign dbl     = {r_power, 1'b0};
    assign n_power = (dbl >= {1'b0, xbsc_pkg::PRIME}) ?
                     xbsc_pkg::COUNT_W'(dbl - {1'b0, xbsc_pkg::PRIME}) :
                     xbsc_pkg::COUNT_W'(dbl);

    // working word and slot counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_w   <= xbsc_pkg::to_word(i_value);
            r_bit <= xbsc_pkg::t_bit_idx'(WB - 1);
        end else if (i_cmd.step) begin
            if (hit) r_w <= r_w ^ r_rows[r_bit];
            r_bit <= r_bit - 1'b1;
        end
    end

    // basis rows, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_op == xbsc_pkg::OP_INSERT) && !residue_zero) begin
            r_rows[r_bit] <= r_w;
        end
    end

    // valid bits, rank and free power
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rank  <= '0;
            r_power <= xbsc_pkg::COUNT_W'(1);
        end else if (i_cmd.commit && (r_op == xbsc_pkg::OP_INSERT)) begin
            if (residue_zero) begin
                r_power <= n_power;
            end else begin
                r_valid[r_bit] <= 1'b1;
                r_rank         <= r_rank + 1'b1;
            end
        end
    end

    // result of the finished request
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_span <= residue_zero;
            priority if (r_op == xbsc_pkg::OP_INSERT) begin
                r_res_count <= residue_zero ? n_power : r_power;
            end else begin
                r_res_count <= residue_zero ? r_power : '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_span  <= r_res_span;
            r_out_count <= r_res_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_in_span   = r_out_span;
    assign o_count     = r_out_count;

`ifndef SYNTHESIS
    // rank tracks the number of filled slots
    a_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_rank))
        else $error("rank does not match filled slots");
    // free power stays reduced
    a_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_power < xbsc_pkg::PRIME)
        else $error("free power not below the prime");
    // a result never overwrites one that is still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result emitted over a pending one");
    // a new basis row marks its slot valid
    a_row_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_op == xbsc_pkg::OP_INSERT) && !residue_zero)
        |=> r_valid[$past(r_bit)])
        else $error("new row not marked valid");
`endif

endmodule

[rtl/xor_basis_subset_count_top.sv]
// ---------------------------------------------------------------------------
// xor_basis_subset_count_top - xor basis subset counter
// Keeps a GF(2) basis of words and counts, modulo 1000000007, the subsets
// of all inserted words whose XOR equals a queried word.
// ---------------------------------------------------------------------------
// Each request (opcode 0 insert, 1 query) is reduced against the basis by a
// single shared XOR step that visits one slot per cycle from the top bit
// down, stopping early at the first empty slot whose bit is set. From
// acceptance to the next acceptance a request is taken, visits its slots
// in turn (the last visit commits) and then loads the output register;
// that load waits for as long as the previous result is still held in
// the output register. Requests are handled one at a time and answered
// in arrival order; the input is taken again while the previous result
// still waits in the output register. After reset the basis is empty
// and the free power is one; no clearing pass is needed.
// ---------------------------------------------------------------------------
module xor_basis_subset_count_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    xbsc_in_if.sink      i_in,
    xbsc_out_if.source   o_out
);

    xbsc_pkg::t_cmd cmd;
    xbsc_pkg::t_sts sts;

    // sequencing
    xbsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // basis and reduction
    xbsc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_opcode    (i_in.opcode),
        .i_value     (i_in.value),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_in_span   (o_out.in_span),
        .o_count     (o_out.count)
    );

endmodule
